// ===== src/mrs_pkg.sv =====
// package for the modbus rtu register slave
// types and constants shared by the top level and the crc unit
package mrs_pkg;

    // input word kinds carried on tuser
    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_GAP     = 2'd1;
    localparam logic [1:0] OP_SENSOR  = 2'd2;

    // modbus function and exception codes
    localparam logic [7:0] FUNC_READ    = 8'd3;
    localparam logic [7:0] FUNC_WRITE   = 8'd6;
    localparam logic [7:0] EXC_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_FLAG     = 8'h80;

    // crc-16 constants
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // reset values
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd250;
    localparam logic [15:0] TABLE_BASE_RST = 16'd1000;
    localparam logic [15:0] TABLE_STEP     = 16'h0010;

    // configuration register indexes
    localparam logic [1:0] CFG_TABLE_BASE  = 2'd0;
    localparam logic [1:0] CFG_SERIAL_READ = 2'd1;
    localparam logic [1:0] CFG_ADDR_CHANGE = 2'd2;
    localparam logic [1:0] CFG_SER_CHANGE  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DECIDE,
        S_EMIT,
        S_CRC
    } t_state;

    // response kinds
    typedef enum logic [1:0] {
        R_SERIAL,
        R_TABLE,
        R_EXCEPT,
        R_WRITE
    } t_resp;

    // control word for the crc unit
    typedef struct packed {
        logic       init;
        logic       load;
        logic       step;
        logic [7:0] data;
    } t_crc_ctl;

endpackage

// ===== src/mrs_ram.sv =====
// generic single port ram with registered read
// no dependencies
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mrs_crc.sv =====
// bit-serial modbus crc-16 unit, one shift step per cycle while step is set
// depends on mrs_pkg
module mrs_crc
    import mrs_pkg::*;
(
    input  logic        i_clk,
    input  t_crc_ctl    i_ctl,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // init, fold in a byte, or one reflected shift
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.load) begin
            n_crc = r_crc ^ {8'h00, i_ctl.data};
        end else if (i_ctl.step) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

// ===== src/modbus_rtu_register_slave_top.sv =====
// modbus rtu register slave top level: frame store, sequencer, response builder
// depends on mrs_pkg, mrs_ram, mrs_crc
//
// channel   dir  handshake             payload
// s_axis    in   i_s_tvalid/o_s_tready tuser=operation, tdata=rx_byte,table_index,table_value
// m_axis    out  o_m_tvalid/i_m_tready tdata=tx_byte, tlast=last
// cfg       in   i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// a received byte or sensor word is taken while idle; a frame gap loads the header from
// the frame store and checks it, then each response byte is sent and shifted bit by bit into the crc,
// followed by the two crc bytes; a stalled output holds the response.
// reset is synchronous, active low; no clearing pass is needed.
module modbus_rtu_register_slave_top
    import mrs_pkg::*;
#(
    parameter int FRAME_DEPTH = 64,
    parameter int TABLE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // rx_byte[7:0], table_index[10:8], table_value[26:11]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // tx_byte[7:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = $clog2(2 * TABLE_DEPTH + 6);
    localparam logic [AW-1:0] CNT_MAX = AW'(FRAME_DEPTH - 1);

    // configuration
    logic [15:0] r_table_base, r_serial_read, r_addr_change, r_ser_change;
    // block state
    logic [AW-1:0] r_count, n_count;
    logic [7:0]    r_slave, n_slave;
    logic [15:0]   r_serial, n_serial;
    logic [15:0]   r_tbl [TABLE_DEPTH];
    // sequencer
    t_state        r_state, n_state;
    logic [2:0]    r_ld, n_ld;
    logic [2:0]    r_bit, n_bit;
    logic [AW-1:0] r_len, n_len;
    logic [7:0]    r_fb [6];
    t_resp         r_kind, n_kind;
    logic [LW-1:0] r_rlen, n_rlen;
    logic [LW-1:0] r_j, n_j;
    logic [7:0]    r_sa, n_sa;
    logic [7:0]    r_code, n_code;
    logic [TW-1:0] r_k0, n_k0;
    // output register
    logic          r_ov, n_ov;
    logic [7:0]    r_od, n_od;
    logic          r_ol, n_ol;

    logic          s_acc;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    t_crc_ctl      crc_ctl;
    logic [15:0]   crc;

    logic [15:0]   req_a, req_q;
    logic [16:0]   a_end, t_end;
    logic          range_bad;
    logic [7:0]    resp_byte;
    logic [LW-1:0] jm3;
    logic [TW-1:0] widx;
    logic [15:0]   tword;
    logic          out_free;
    logic          tbl_we;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_ov || i_m_tready;

    mrs_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_s_tdata[7:0]),
        .o_rdata (ram_rdata)
    );

    mrs_crc u_crc (
        .i_clk (i_clk),
        .i_ctl (crc_ctl),
        .o_crc (crc)
    );

    // request fields and read range check
    assign req_a     = {r_fb[2], r_fb[3]};
    assign req_q     = {r_fb[4], r_fb[5]};
    assign a_end     = {1'b0, req_a} + {1'b0, req_q};
    assign t_end     = {1'b0, r_table_base} + 17'(TABLE_DEPTH);
    assign range_bad = (req_a < r_table_base) || (a_end > t_end);

    // table word for the current data byte
    assign jm3   = r_j - LW'(3);
    assign widx  = r_k0 + TW'(jm3 >> 1);
    assign tword = r_tbl[widx];

    // response byte selection
    always_comb begin
        resp_byte = 8'h00;
        if (r_j == '0) begin
            resp_byte = r_sa;
        end else begin
            case (r_kind)
                R_SERIAL: begin
                    case (r_j)
                        LW'(1):  resp_byte = FUNC_READ;
                        LW'(2):  resp_byte = 8'd2;
                        LW'(3):  resp_byte = r_serial[15:8];
                        default: resp_byte = r_serial[7:0];
                    endcase
                end
                R_TABLE: begin
                    if (r_j == LW'(1)) begin
                        resp_byte = FUNC_READ;
                    end else if (r_j == LW'(2)) begin
                        resp_byte = 8'(r_rlen - LW'(3));
                    end else begin
                        resp_byte = r_j[0] ? tword[15:8] : tword[7:0];
                    end
                end
                R_EXCEPT: begin
                    resp_byte = (r_j == LW'(1)) ? (r_fb[1] | EXC_FLAG) : r_code;
                end
                default: begin
                    case (r_j)
                        LW'(1):  resp_byte = FUNC_WRITE;
                        LW'(2):  resp_byte = r_fb[2];
                        LW'(3):  resp_byte = r_fb[3];
                        LW'(4):  resp_byte = r_fb[4];
                        default: resp_byte = r_fb[5];
                    endcase
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser == OP_GAP) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_ld == 3'd6) begin
                    n_state = (r_len > AW'(2)) ? S_DECIDE : S_IDLE;
                end
            end
            S_DECIDE: begin
                if (r_fb[0] != r_slave) begin
                    n_state = S_IDLE;
                end else if (r_fb[1] == FUNC_READ &&
                             {1'b0, r_len} != (AW+1)'(8)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_j < r_rlen) begin
                        n_state = S_CRC;
                    end else if (r_j != r_rlen) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CRC: begin
                if (r_bit == 3'd7) begin
                    n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_slave  = r_slave;
        n_serial = r_serial;
        n_ld     = r_ld;
        n_bit    = r_bit;
        n_len    = r_len;
        n_kind   = r_kind;
        n_rlen   = r_rlen;
        n_j      = r_j;
        n_sa     = r_sa;
        n_code   = r_code;
        n_k0     = r_k0;
        n_ov     = r_ov && !i_m_tready;
        n_od     = r_od;
        n_ol     = r_ol;
        ram_we   = 1'b0;
        ram_addr = r_count;
        tbl_we   = 1'b0;
        crc_ctl  = '{init: 1'b0, load: 1'b0, step: 1'b0, data: 8'h00};
        unique case (r_state)
            S_IDLE: begin
                n_ld = '0;
                if (s_acc) begin
                    case (i_s_tuser)
                        OP_RX_BYTE: begin
                            ram_we  = 1'b1;
                            n_count = (r_count == CNT_MAX) ? CNT_MAX : r_count + AW'(1);
                        end
                        OP_GAP: begin
                            n_len   = r_count;
                            n_count = '0;
                        end
                        OP_SENSOR: begin
                            tbl_we = ({29'd0, i_s_tdata[10:8]} < 32'(TABLE_DEPTH));
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                ram_addr = AW'(r_ld);
                n_ld     = r_ld + 3'd1;
            end
            S_DECIDE: begin
                n_sa   = r_slave;
                n_j    = '0;
                n_k0   = TW'(req_a - r_table_base);
                crc_ctl.init = 1'b1;
                if (r_fb[1] == FUNC_READ) begin
                    if (req_a == r_serial_read && req_q == 16'd1) begin
                        n_kind = R_SERIAL;
                        n_rlen = LW'(5);
                    end else if (range_bad) begin
                        n_kind = R_EXCEPT;
                        n_code = EXC_ADDRESS;
                        n_rlen = LW'(3);
                    end else begin
                        n_kind = R_TABLE;
                        n_rlen = LW'(3) + {req_q[LW-2:0], 1'b0};
                    end
                end else if (r_fb[1] == FUNC_WRITE) begin
                    n_kind = R_WRITE;
                    n_rlen = LW'(6);
                    if (r_fb[0] == r_slave) begin
                        if (req_a == r_addr_change) begin
                            n_slave = r_fb[5];
                        end
                        if (req_a == r_ser_change) begin
                            n_serial = req_q;
                        end
                    end
                end else begin
                    n_kind = R_EXCEPT;
                    n_code = EXC_FUNCTION;
                    n_rlen = LW'(3);
                end
            end
            S_EMIT: begin
                n_bit = '0;
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ol = 1'b0;
                    n_j  = r_j + LW'(1);
                    if (r_j < r_rlen) begin
                        n_od         = resp_byte;
                        crc_ctl.load = 1'b1;
                        crc_ctl.data = resp_byte;
                    end else if (r_j == r_rlen) begin
                        n_od = crc[7:0];
                    end else begin
                        n_od = crc[15:8];
                        n_ol = 1'b1;
                    end
                end
            end
            S_CRC: begin
                crc_ctl.step = 1'b1;
                n_bit        = r_bit + 3'd1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_slave       <= SLAVE_ADDR_RST;
            r_serial      <= '0;
            r_ov          <= 1'b0;
            r_table_base  <= TABLE_BASE_RST;
            r_serial_read <= '0;
            r_addr_change <= '0;
            r_ser_change  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_slave  <= n_slave;
            r_serial <= n_serial;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TABLE_BASE:  r_table_base  <= i_cfg_wdata;
                    CFG_SERIAL_READ: r_serial_read <= i_cfg_wdata;
                    CFG_ADDR_CHANGE: r_addr_change <= i_cfg_wdata;
                    CFG_SER_CHANGE:  r_ser_change  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // measurement table
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!i_rst_n) begin
                r_tbl[i] <= 16'(TABLE_STEP * 16'(i + 1));
            end else if (tbl_we && 32'(i_s_tdata[10:8]) == i) begin
                r_tbl[i] <= i_s_tdata[26:11];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ld   <= n_ld;
        r_bit  <= n_bit;
        r_len  <= n_len;
        r_kind <= n_kind;
        r_rlen <= n_rlen;
        r_j    <= n_j;
        r_sa   <= n_sa;
        r_code <= n_code;
        r_k0   <= n_k0;
        r_od   <= n_od;
        r_ol   <= n_ol;
        if (r_state == S_LOAD && r_ld != 3'd0) begin
            r_fb[r_ld - 3'd1] <= ram_rdata;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tlast  = r_ol;

endmodule

// ===== src/mrs_checker.sv =====
// port-level checker for the modbus rtu register slave
// depends on mrs_pkg and modbus_rtu_register_slave_top, attached by bind
module mrs_checker
    import mrs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [1:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // a stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    // a frame gap makes the block busy
    a_gap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_GAP |=> !o_s_tready)
        else $error("ready after frame gap");

    // a received byte keeps the block ready
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_RX_BYTE |=> o_s_tready)
        else $error("busy after received byte");

    // while ready only the final byte of a response may wait
    a_idle_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && o_m_tvalid |-> o_m_tlast)
        else $error("response in flight while ready");

endmodule

bind modbus_rtu_register_slave_top mrs_checker u_mrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== bench/modbus_rtu_register_slave_top_tb.sv =====
// testbench for the modbus rtu register slave: drives frames, gaps and sensor words,
// predicts every response byte with its own slave model and checks the output stream
// depends on mrs_pkg and modbus_rtu_register_slave_top
module modbus_rtu_register_slave_top_tb;
    import mrs_pkg::*;

    localparam int FRAME_DEPTH = 64;
    localparam int TABLE_DEPTH = 8;
    localparam int SETTLE      = 300;
    localparam int IDLE_LIMIT  = 5000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  rx;
        logic [2:0]  idx;
        logic [15:0] val;
    } t_item;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } t_resp_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    modbus_rtu_register_slave_top #(
        .FRAME_DEPTH(FRAME_DEPTH),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // pending words, expected response bytes, run status
    t_item      word_q[$];
    t_resp_byte resp_q[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         word_took = 1'b0;
    bit         quiet = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;

    // slave model state
    logic [7:0]  fr_mem [FRAME_DEPTH];
    int          fr_cnt;
    logic [7:0]  dev_addr;
    logic [15:0] serial_no;
    logic [15:0] meas [TABLE_DEPTH];
    logic [15:0] resp_crc;
    logic [15:0] base_reg, ser_rd_reg, addr_chg_reg, ser_chg_reg;

    // address the stimulus believes the slave answers to
    logic [7:0]  gen_addr;

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic emit(logic [7:0] b);
        resp_q.push_back('{b, 1'b0});
        resp_crc = crc_next(resp_crc, b);
    endtask

    task automatic seal();
        resp_q.push_back('{resp_crc[7:0], 1'b0});
        resp_q.push_back('{resp_crc[15:8], 1'b1});
    endtask

    task automatic except_resp(logic [7:0] func, logic [7:0] code);
        resp_crc = CRC_INIT;
        emit(dev_addr);
        emit(func | EXC_FLAG);
        emit(code);
        seal();
    endtask

    // frame handling at a gap
    task automatic answer_frame();
        logic [7:0]  func;
        logic [15:0] a, q;
        int          k;
        logic [15:0] w;
        func = fr_mem[1];
        a = {fr_mem[2], fr_mem[3]};
        q = {fr_mem[4], fr_mem[5]};
        if (fr_mem[0] != dev_addr) return;
        if (func == FUNC_READ) begin
            if (fr_cnt != 8) return;
            if (a == ser_rd_reg && q == 16'd1) begin
                resp_crc = CRC_INIT;
                emit(dev_addr); emit(FUNC_READ); emit(8'd2);
                emit(serial_no[15:8]); emit(serial_no[7:0]);
                seal();
            end else if (a < base_reg ||
                         {16'd0, a} + {16'd0, q} > {16'd0, base_reg} + TABLE_DEPTH) begin
                except_resp(FUNC_READ, EXC_ADDRESS);
            end else begin
                resp_crc = CRC_INIT;
                emit(dev_addr); emit(FUNC_READ); emit(8'(q * 2));
                for (int i = 0; i < q; i++) begin
                    k = int'(a) - int'(base_reg) + i;
                    w = (k < TABLE_DEPTH) ? meas[k] : 16'd0;
                    emit(w[15:8]); emit(w[7:0]);
                end
                seal();
            end
        end else if (func == FUNC_WRITE) begin
            resp_crc = CRC_INIT;
            emit(dev_addr); emit(FUNC_WRITE);
            emit(a[15:8]); emit(a[7:0]); emit(q[15:8]); emit(q[7:0]);
            seal();
            if (a == addr_chg_reg) dev_addr = q[7:0];
            if (a == ser_chg_reg) serial_no = q;
        end else begin
            except_resp(func, EXC_FUNCTION);
        end
    endtask

    task automatic predict_word(t_item it);
        case (it.op)
            OP_RX_BYTE: begin
                if (fr_cnt > FRAME_DEPTH - 1) fr_cnt = FRAME_DEPTH - 1;
                fr_mem[fr_cnt] = it.rx;
                fr_cnt++;
                if (fr_cnt > FRAME_DEPTH - 1) fr_cnt = FRAME_DEPTH - 1;
            end
            OP_GAP: begin
                if (fr_cnt > 2) answer_frame();
                fr_cnt = 0;
            end
            OP_SENSOR: begin
                if (int'(it.idx) < TABLE_DEPTH) meas[it.idx] = it.val;
            end
            default: ;
        endcase
    endtask

    // stimulus helpers
    task automatic add_byte(logic [7:0] b);
        word_q.push_back('{OP_RX_BYTE, b, 3'($urandom), 16'($urandom)});
    endtask

    task automatic add_gap();
        word_q.push_back('{OP_GAP, 8'($urandom), 3'($urandom), 16'($urandom)});
    endtask

    task automatic add_sensor(logic [2:0] idx, logic [15:0] val);
        word_q.push_back('{OP_SENSOR, 8'($urandom), idx, val});
    endtask

    // request of 8 bytes plus gap; crc bytes are random since the slave ignores them
    task automatic add_frame(logic [7:0] addr, logic [7:0] func, logic [15:0] a,
                             logic [15:0] q);
        add_byte(addr); add_byte(func);
        add_byte(a[15:8]); add_byte(a[7:0]);
        add_byte(q[15:8]); add_byte(q[7:0]);
        add_byte(8'($urandom)); add_byte(8'($urandom));
        add_gap();
        if (addr == gen_addr && func == FUNC_WRITE && a == addr_chg_reg)
            gen_addr = q[7:0];
    endtask

    task automatic add_random_txn();
        int          r, n;
        logic [15:0] a, q;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            if ($urandom_range(0, 4) == 0) begin
                a = ser_rd_reg; q = 16'd1;
            end else begin
                a = base_reg + 16'($urandom_range(0, 9)) - 16'd1;
                q = 16'($urandom_range(0, 9));
                if ($urandom_range(0, 9) == 0) q = 16'($urandom);
            end
            add_frame(gen_addr, FUNC_READ, a, q);
        end else if (r < 50) begin
            case ($urandom_range(0, 3))
                0: a = addr_chg_reg;
                1: a = ser_chg_reg;
                2: a = ser_rd_reg;
                default: a = 16'($urandom);
            endcase
            add_frame(gen_addr, FUNC_WRITE, a, 16'($urandom));
        end else if (r < 58) begin
            add_frame(gen_addr, 8'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 73) begin
            add_sensor(3'($urandom), 16'($urandom));
        end else if (r < 80) begin
            add_frame(gen_addr + 8'd1, FUNC_READ, base_reg, 16'd1);
        end else if (r < 90) begin
            // broken read length
            n = $urandom_range(0, 1) ? 7 : 9;
            add_byte(gen_addr); add_byte(FUNC_READ);
            for (int i = 2; i < n; i++) add_byte(8'($urandom));
            add_gap();
        end else begin
            // noise: foreign or short bytes, or an unused word kind
            n = $urandom_range(0, 8);
            if (n > 0) add_byte(gen_addr ^ 8'h5A);
            for (int i = 1; i < n; i++) add_byte(8'($urandom));
            if ($urandom_range(0, 1))
                word_q.push_back('{OP_UNUSED, 8'($urandom), 3'($urandom), 16'($urandom)});
            add_gap();
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_TABLE_BASE:  base_reg     = val;
            CFG_SERIAL_READ: ser_rd_reg   = val;
            CFG_ADDR_CHANGE: addr_chg_reg = val;
            default:         ser_chg_reg  = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (word_q.size() != 0 || i_s_tvalid || resp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] b, logic [15:0] s, logic [15:0] ac, logic [15:0] sc);
        cfg_write(CFG_TABLE_BASE, b);
        cfg_write(CFG_SERIAL_READ, s);
        cfg_write(CFG_ADDR_CHANGE, ac);
        cfg_write(CFG_SER_CHANGE, sc);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // input driver
    always @(negedge i_clk) begin
        t_item it;
        logic  v;
        v = i_s_tvalid;
        if (i_rst_n && (!i_s_tvalid || word_took)) begin
            v = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (word_q.size() != 0) begin
                it = word_q.pop_front();
                i_s_tuser <= it.op;
                i_s_tdata <= {5'd0, it.val, it.idx, it.rx};
                v = 1'b1;
                send_gap <= pick_gap();
            end
        end
        i_s_tvalid <= v;
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            i_m_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else begin
            i_m_tready <= 1'b1;
            recv_stall <= pick_gap();
        end
    end

    // model update on accepted words, response check, watchdog
    always @(posedge i_clk) begin
        t_resp_byte e;
        bit         busy;
        busy = i_cfg_we;
        word_took <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            busy = 1'b1;
            if (resp_q.size() == 0) begin
                $display("%0t: unexpected word tdata=%h tlast=%b", $time, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                e = resp_q.pop_front();
                if (o_m_tdata !== e.tx) begin
                    $display("%0t: tx_byte expected %h actual %h", $time, e.tx, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, o_m_tlast);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            busy = 1'b1;
            predict_word('{i_s_tuser, i_s_tdata[7:0], i_s_tdata[10:8], i_s_tdata[26:11]});
        end
        idle_cycles <= busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // reset, directed part, then random phases over several settings
    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_RX_BYTE;
        i_m_tready  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= CFG_TABLE_BASE;
        i_cfg_wdata <= '0;
        for (int i = 0; i < FRAME_DEPTH; i++) fr_mem[i] = 8'h00;
        for (int i = 0; i < TABLE_DEPTH; i++) meas[i] = TABLE_STEP * 16'(i + 1);
        fr_cnt = 0; dev_addr = SLAVE_ADDR_RST; serial_no = 16'd0; resp_crc = CRC_INIT;
        base_reg = TABLE_BASE_RST; ser_rd_reg = 16'd0;
        addr_chg_reg = 16'd0; ser_chg_reg = 16'd0;
        gen_addr = SLAVE_ADDR_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first frame is foreign so the whole header area gets written
        add_frame(8'd17, FUNC_READ, 16'd0, 16'd0);
        add_frame(gen_addr, FUNC_READ, 16'd1000, 16'd8);
        add_frame(gen_addr, FUNC_READ, 16'd1000, 16'd0);
        add_frame(gen_addr, FUNC_READ, 16'd999, 16'd1);
        add_frame(gen_addr, FUNC_READ, 16'd1007, 16'd2);
        add_frame(gen_addr, FUNC_READ, 16'd0, 16'd1);
        add_frame(gen_addr, 8'h41, 16'hFFFF, 16'hFFFF);
        add_frame(gen_addr, 8'hFF, 16'd0, 16'd0);
        add_sensor(3'd7, 16'hFFFF);
        add_sensor(3'd0, 16'h0000);
        word_q.push_back('{OP_UNUSED, 8'hFF, 3'd7, 16'hFFFF});
        add_frame(gen_addr, FUNC_READ, 16'd1007, 16'd1);
        add_byte(gen_addr); add_byte(FUNC_READ); add_gap();
        add_frame(gen_addr, FUNC_WRITE, 16'd5, 16'hABCD);
        // store overflow: a long write frame, last entry keeps being overwritten
        add_byte(gen_addr); add_byte(FUNC_WRITE);
        add_byte(8'h01); add_byte(8'h00); add_byte(8'h55); add_byte(8'hAA);
        for (int i = 0; i < 66; i++) add_byte(8'($urandom));
        add_gap();
        // both change registers match: new address and serial number together
        add_frame(gen_addr, FUNC_WRITE, 16'd0, 16'h1234);
        add_frame(gen_addr, FUNC_READ, 16'd0, 16'd1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_all(16'd0, 16'hFFFF, 16'd1, 16'd2);
                1: set_all(16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF);
                2: set_all(16'd500, 16'd508, 16'd500, 16'd501);
                default: set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            quiet = (ph == 2);
            for (int t = 0; t < 2; t++) add_random_txn();
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
